### hw/rtl/bdc_pkg.sv
`default_nettype none

package bdc_pkg;

   // Field widths.
   localparam int T_W      = 16;
   localparam int VALUE_W  = 32;
   localparam int DEGREE_W = 3;

   // Configuration port.
   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 32;

   // Register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_DEGREE = 4'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_COEF_0 = 4'd1;

   // Number of coefficient registers in the register map.
   localparam int MAP_COEFS = 7;

   // One in Q1.15, and the number of fraction bits of the parameter.
   localparam logic [T_W-1:0] T_ONE  = 16'd32768;
   localparam int             T_FRAC = 15;

   // Header that travels down the pipeline with each request.
   typedef struct packed {
      logic           valid;
      logic [T_W-1:0] t;
   } stage_hdr_type;

endpackage

`default_nettype wire

### hw/rtl/bdc_req_if.sv
`default_nettype none

interface bdc_req_if;
   logic                     valid;
   logic                     ready;
   logic [bdc_pkg::T_W-1:0]  param_t;

   modport source (output valid, output param_t, input ready);
   modport sink   (input valid, input param_t, output ready);
endinterface

`default_nettype wire

### hw/rtl/bdc_rsp_if.sv
`default_nettype none

interface bdc_rsp_if;
   logic                               valid;
   logic                               ready;
   logic signed [bdc_pkg::VALUE_W-1:0] value;

   modport source (output valid, output value, input ready);
   modport sink   (input valid, input value, output ready);
endinterface

`default_nettype wire

### hw/rtl/bernstein_de_casteljau_eval_top.sv
// Bernstein polynomial evaluator using the de Casteljau triangle.
//
// Configuration: csr_we, csr_index and csr_wdata write the degree (index 0)
// and the coefficients coef_0 to coef_6 (indexes 1 to 7, signed Q16.16).
// The user must make writes only while no request is in flight (unenforced).
// Requests arrive on req_bus carrying param_t in unsigned Q1.15; values above
// one are clamped to one. Each request gives one response on rsp_bus with the
// signed Q16.16 value of the polynomial at that parameter.
// Each request passes one input register plus one register stage per level
// of the triangle. A new request is accepted every cycle until a stall fills every stage.
// When the receiver stalls, the response holds on rsp_bus and the pipeline
// fills its empty stages; req_bus.ready falls only once every stage is full.
// Reset clears the degree and all coefficients to zero and empties the
// pipeline.
`default_nettype none

module bernstein_de_casteljau_eval_top #(
   parameter int MAX_DEGREE = 6
) (
   input  wire logic                             clock,
   input  wire logic                             reset,
   bdc_req_if.sink                               req_bus,
   bdc_rsp_if.source                             rsp_bus,
   input  wire logic                             csr_we,
   input  wire logic [bdc_pkg::CSR_IDX_W-1:0]    csr_index,
   input  wire logic [bdc_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   localparam int NUM_COEFS = MAX_DEGREE + 1;

   logic [bdc_pkg::DEGREE_W-1:0]        degree_ff;
   logic signed [bdc_pkg::VALUE_W-1:0]  coef_ff [NUM_COEFS];
   logic [bdc_pkg::DEGREE_W-1:0]        deg_sat;

   bdc_pkg::stage_hdr_type              s0_hdr_ff;
   logic signed [bdc_pkg::VALUE_W-1:0]  s0_work_ff [NUM_COEFS];
   logic [bdc_pkg::T_W-1:0]             t_sat;

   bdc_pkg::stage_hdr_type              hdr  [MAX_DEGREE+1];
   logic signed [bdc_pkg::VALUE_W-1:0]  work [MAX_DEGREE+1][NUM_COEFS];
   logic                                rdy  [MAX_DEGREE+2];

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         degree_ff <= '0;
         for (int i = 0; i < NUM_COEFS; i++) begin
            coef_ff[i] <= '0;
         end
      end else if (csr_we) begin
         if (csr_index == bdc_pkg::CSR_DEGREE) begin
            degree_ff <= csr_wdata[bdc_pkg::DEGREE_W-1:0];
         end
         for (int i = 0; i < NUM_COEFS; i++) begin
            if (csr_index == bdc_pkg::CSR_COEF_0 + bdc_pkg::CSR_IDX_W'(i)) begin
               coef_ff[i] <= csr_wdata;
            end
         end
      end
   end

   assign deg_sat = (degree_ff > bdc_pkg::DEGREE_W'(MAX_DEGREE)) ?
                    bdc_pkg::DEGREE_W'(MAX_DEGREE) : degree_ff;

   assign t_sat = (req_bus.param_t > bdc_pkg::T_ONE) ? bdc_pkg::T_ONE : req_bus.param_t;

   // Input stage: clamp the parameter and load the first row of the triangle.
   assign rdy[0]        = !s0_hdr_ff.valid || rdy[1];
   assign req_bus.ready = rdy[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         s0_hdr_ff.valid <= 1'b0;
      end else if (rdy[0]) begin
         s0_hdr_ff.valid <= req_bus.valid;
      end
      if (rdy[0] && req_bus.valid) begin
         s0_hdr_ff.t <= t_sat;
         s0_work_ff  <= coef_ff;
      end
   end

   assign hdr[0]  = s0_hdr_ff;
   assign work[0] = s0_work_ff;

   // Level k does MAX_DEGREE - k + 1 interpolations if degree is that or more.
   for (genvar k = 1; k <= MAX_DEGREE; k++) begin : g_level
      bdc_stage #(
         .NUM_COEFS (NUM_COEFS),
         .NUM_LERPS (MAX_DEGREE - k + 1)
      ) u_stage (
         .clock    (clock),
         .reset    (reset),
         .degree   (deg_sat),
         .up_hdr   (hdr[k-1]),
         .up_work  (work[k-1]),
         .up_ready (rdy[k]),
         .dn_hdr   (hdr[k]),
         .dn_work  (work[k]),
         .dn_ready (rdy[k+1])
      );
   end

   assign rdy[MAX_DEGREE+1] = rsp_bus.ready;
   assign rsp_bus.valid     = hdr[MAX_DEGREE].valid;
   assign rsp_bus.value     = work[MAX_DEGREE][0];

endmodule

`default_nettype wire

### hw/rtl/bdc_stage.sv
`default_nettype none

module bdc_stage #(
   parameter int NUM_COEFS = 7,
   parameter int NUM_LERPS = 6
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic [bdc_pkg::DEGREE_W-1:0]          degree,
   input  wire bdc_pkg::stage_hdr_type                up_hdr,
   input  wire logic signed [bdc_pkg::VALUE_W-1:0]    up_work [NUM_COEFS],
   output      logic                                  up_ready,
   output      bdc_pkg::stage_hdr_type                dn_hdr,
   output      logic signed [bdc_pkg::VALUE_W-1:0]    dn_work [NUM_COEFS],
   input  wire logic                                  dn_ready
);

   localparam int DIFF_W = bdc_pkg::VALUE_W + 1;
   localparam int MULT_W = DIFF_W + bdc_pkg::T_W + 1;
   localparam int SUM_W  = MULT_W + 1;

   bdc_pkg::stage_hdr_type               hdr_ff;
   logic signed [bdc_pkg::VALUE_W-1:0]   work_ff [NUM_COEFS];
   logic signed [bdc_pkg::VALUE_W-1:0]   work_in [NUM_COEFS];
   logic                                 active;

   // a + t*(b - a), which equals (1 - t)*a + t*b, with one multiplier.
   function automatic logic signed [bdc_pkg::VALUE_W-1:0] lerp(
      input logic signed [bdc_pkg::VALUE_W-1:0] a,
      input logic signed [bdc_pkg::VALUE_W-1:0] b,
      input logic        [bdc_pkg::T_W-1:0]     t
   );
      logic signed [DIFF_W-1:0] diff;
      logic signed [MULT_W-1:0] prod;
      logic signed [SUM_W-1:0]  sum;
      diff = DIFF_W'(b) - DIFF_W'(a);
      prod = diff * $signed({1'b0, t});
      sum  = (SUM_W'(a) <<< bdc_pkg::T_FRAC) + SUM_W'(prod)
             + (SUM_W'(1) <<< (bdc_pkg::T_FRAC - 1));
      return sum[bdc_pkg::T_FRAC +: bdc_pkg::VALUE_W];
   endfunction

   // This level of the triangle only takes part when the degree reaches it;
   // lower degrees pass the row through unchanged.
   assign active = (degree >= bdc_pkg::DEGREE_W'(NUM_LERPS));

   always_comb begin
      work_in = up_work;
      if (active) begin
         for (int i = 0; i < NUM_LERPS; i++) begin
            work_in[i] = lerp(up_work[i], up_work[i+1], up_hdr.t);
         end
      end
   end

   assign up_ready = !hdr_ff.valid || dn_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         hdr_ff.valid <= 1'b0;
      end else if (up_ready) begin
         hdr_ff.valid <= up_hdr.valid;
      end
      if (up_ready && up_hdr.valid) begin
         hdr_ff.t <= up_hdr.t;
         work_ff  <= work_in;
      end
   end

   assign dn_hdr  = hdr_ff;
   assign dn_work = work_ff;

endmodule

`default_nettype wire

### hw/rtl/bdc_checker.sv
`default_nettype none

module bdc_checker (
   input wire logic                               clock,
   input wire logic                               reset,
   input wire logic                               req_ready,
   input wire logic                               rsp_valid,
   input wire logic                               rsp_ready,
   input wire logic signed [bdc_pkg::VALUE_W-1:0] rsp_value
);

   // Reset empties the pipeline, so no response follows it.
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response presented straight after reset");

   // When the last stage is empty or drains, every stage can move, so a
   // request must be accepted.
   assert property (@(posedge clock) disable iff (reset)
      (!rsp_valid || rsp_ready) |-> req_ready)
      else $error("request refused although the pipeline can advance");

   // A stalled response stays and holds its value.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(rsp_value)))
      else $error("stalled response dropped or changed");

endmodule

bind bernstein_de_casteljau_eval_top bdc_checker u_bdc_checker (
   .clock     (clock),
   .reset     (reset),
   .req_ready (req_bus.ready),
   .rsp_valid (rsp_bus.valid),
   .rsp_ready (rsp_bus.ready),
   .rsp_value (rsp_bus.value)
);

`default_nettype wire
